FILE: rtl/core/sv39ptw_pkg.sv
// Shared types and constants of the Sv39 page table walker.
// Holds the input and result word layouts and the entry bit positions.
// Depends on nothing.
package sv39ptw_pkg;

  typedef enum logic {
    CMD_TRANSLATE = 1'b0,
    CMD_ENTRY     = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_READ  = 2'd0,
    KIND_DONE  = 2'd1,
    KIND_FAULT = 2'd2
  } kind_e;

  localparam int unsigned RootW  = 44;
  localparam int unsigned VaW    = 39;
  localparam int unsigned PteW   = 64;
  localparam int unsigned RaddrW = 56;
  localparam int unsigned PaddrW = 57;

  localparam int unsigned PteValid = 0;
  localparam int unsigned PteRead  = 1;
  localparam int unsigned PteWrite = 2;
  localparam int unsigned PteExec  = 3;
  localparam int unsigned PpnLo    = 10;
  localparam int unsigned PpnHi    = 53;

  localparam logic [1:0] LevelRoot = 2'd3;
  localparam logic [1:0] LevelMid  = 2'd2;
  localparam logic [1:0] LevelLeaf = 2'd1;

  typedef struct packed {
    cmd_e                  command;
    logic [VaW-1:0]        virt_addr;
    logic [PteW-1:0]       entry_data;
  } in_word_t;

  typedef struct packed {
    kind_e                 kind;
    logic [RaddrW-1:0]     read_addr;
    logic [PaddrW-1:0]     phys_addr;
    logic [1:0]            page_level;
  } out_word_t;

endpackage

FILE: rtl/core/sv39ptw_walk.sv
// Walk state and the single step of the Sv39 translation.
// Depends on sv39ptw_pkg for the word layouts and entry bit positions.
module sv39ptw_walk (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          step_i,
  input  sv39ptw_pkg::in_word_t         word_i,
  input  logic [sv39ptw_pkg::RootW-1:0] root_ppn_i,
  output logic                          res_valid_o,
  output sv39ptw_pkg::out_word_t        res_o
);

  logic                        busy_q, busy_d;
  logic [1:0]                  level_q, level_d;
  logic [sv39ptw_pkg::VaW-1:0] va_q, va_d;

  logic [1:0]                     lvl;
  logic [1:0]                     next_lvl;
  logic [sv39ptw_pkg::RaddrW-1:0] base;
  logic [sv39ptw_pkg::RaddrW-1:0] table_base;
  logic [sv39ptw_pkg::VaW-1:0]    va;
  logic [8:0]                     idx;
  logic [29:0]                    offset;
  logic                           is_leaf;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      level_q <= sv39ptw_pkg::LevelRoot;
      va_q    <= '0;
    end else if (step_i) begin
      busy_q  <= busy_d;
      level_q <= level_d;
      va_q    <= va_d;
    end
  end

  always_comb begin
    lvl        = (level_q == 2'd0) ? sv39ptw_pkg::LevelLeaf : level_q;
    next_lvl   = lvl - 2'd1;
    base       = {word_i.entry_data[sv39ptw_pkg::PpnHi:sv39ptw_pkg::PpnLo], 12'b0};
    is_leaf    = word_i.entry_data[sv39ptw_pkg::PteRead]
              || word_i.entry_data[sv39ptw_pkg::PteWrite]
              || word_i.entry_data[sv39ptw_pkg::PteExec]
              || (lvl == sv39ptw_pkg::LevelLeaf);
    va         = va_q;
    table_base = base;
    idx        = va_q[20:12];

    case (lvl)
      sv39ptw_pkg::LevelRoot: offset = va_q[29:0];
      sv39ptw_pkg::LevelMid:  offset = {9'b0, va_q[20:0]};
      default:                offset = {18'b0, va_q[11:0]};
    endcase

    busy_d      = busy_q;
    level_d     = level_q;
    va_d        = va_q;
    res_valid_o = 1'b0;
    res_o       = '0;

    if (word_i.command == sv39ptw_pkg::CMD_TRANSLATE) begin
      if (!busy_q) begin
        va         = word_i.virt_addr;
        table_base = {root_ppn_i, 12'b0};
        idx        = word_i.virt_addr[38:30];
        busy_d     = 1'b1;
        level_d    = sv39ptw_pkg::LevelRoot;
        va_d       = word_i.virt_addr;
        res_valid_o      = 1'b1;
        res_o.kind       = sv39ptw_pkg::KIND_READ;
        res_o.read_addr  = {table_base[sv39ptw_pkg::RaddrW-1:12], idx, 3'b0};
        res_o.page_level = sv39ptw_pkg::LevelRoot;
      end
    end else if (busy_q) begin
      res_valid_o = 1'b1;
      if (!word_i.entry_data[sv39ptw_pkg::PteValid]) begin
        busy_d           = 1'b0;
        level_d          = sv39ptw_pkg::LevelRoot;
        res_o.kind       = sv39ptw_pkg::KIND_FAULT;
        res_o.page_level = lvl;
      end else if (is_leaf) begin
        busy_d           = 1'b0;
        level_d          = sv39ptw_pkg::LevelRoot;
        res_o.kind       = sv39ptw_pkg::KIND_DONE;
        res_o.phys_addr  = {1'b0, base} + {27'b0, offset};
        res_o.page_level = lvl;
      end else begin
        idx              = (next_lvl == sv39ptw_pkg::LevelMid) ? va[29:21] : va[20:12];
        level_d          = next_lvl;
        res_o.kind       = sv39ptw_pkg::KIND_READ;
        res_o.read_addr  = {table_base[sv39ptw_pkg::RaddrW-1:12], idx, 3'b0};
        res_o.page_level = next_lvl;
      end
    end
  end

endmodule

FILE: rtl/core/sv39_page_table_walker_core.sv
// Top level of the Sv39 page table walker: input register, walk step, result register.
// Depends on sv39ptw_pkg and sv39ptw_walk.
//
//   Channel   Direction  Handshake                 Word
//   input     in         in_valid_i / in_ready_o   in_word_i  (in_word_t)
//   result    out        out_valid_o / out_ready_i out_word_o (out_word_t)
//   config    in         cfg_we_i                  cfg_wdata_i (root page number)
//
// One word is accepted every cycle unless a result waits on a full, stalled output register.
// The walk step is one pass of mask, select and add logic between the two registers.
// Reset clears the walk to idle at the root level and the root page number to zero.
// A stalled result holds in the output register while the input register still drains
// words that produce no result.
module sv39_page_table_walker_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  sv39ptw_pkg::in_word_t         in_word_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output sv39ptw_pkg::out_word_t        out_word_o,
  input  logic                          cfg_we_i,
  input  logic [sv39ptw_pkg::RootW-1:0] cfg_wdata_i
);

  logic [sv39ptw_pkg::RootW-1:0] root_q;
  logic                          in_valid_q;
  sv39ptw_pkg::in_word_t         in_q;
  logic                          out_valid_q;
  sv39ptw_pkg::out_word_t        out_q;

  logic                          res_valid;
  sv39ptw_pkg::out_word_t        res;
  logic                          out_load;
  logic                          step;

  assign out_load    = !out_valid_q || out_ready_i;
  assign step        = in_valid_q && (!res_valid || out_load);
  assign in_ready_o  = !in_valid_q || step;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  sv39ptw_walk u_walk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .word_i      (in_q),
    .root_ppn_i  (root_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      root_q <= '0;
    end else if (cfg_we_i) begin
      root_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      in_valid_q <= 1'b1;
    end else if (step) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_word_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step && res_valid) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && res_valid) begin
      out_q <= res;
    end
  end

endmodule

FILE: tb/sv39_page_table_walker_core_test.sv
// Self-checking testbench for the Sv39 page table walker core.
// Walks a directed table, then random walks under random stalls, against a behavioral walker.
// Depends on sv39ptw_pkg and sv39_page_table_walker_core.
module sv39_page_table_walker_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import sv39ptw_pkg::*;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned ChokeCycles = 300;

  typedef struct {
    in_word_t  word;
    bit        typed;
    out_word_t want;
  } probe_t;

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             in_valid_i;
  logic             in_ready_o;
  in_word_t         in_word_i;
  logic             out_valid_o;
  logic             out_ready_i;
  out_word_t        out_word_o;
  logic             cfg_we_i;
  logic [RootW-1:0] cfg_wdata_i;

  int unsigned      err_count = 0;
  out_word_t        pending_results[$];
  probe_t           directed_rows[$];

  bit               walk_busy_q = 1'b0;
  logic [1:0]       walk_level_q = LevelRoot;
  logic [VaW-1:0]   walk_va_q = '0;
  logic [RootW-1:0] root_ppn_q = '0;

  bit               send_calm = 1'b0;
  bit               sink_calm = 1'b0;
  bit               choke_req = 1'b0;
  logic             choke = 1'b0;

  sv39_page_table_walker_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [RaddrW-1:0] entry_read_addr(input logic [RaddrW-1:0] tbase,
                                                        input logic [1:0] lvl);
    logic [8:0] idx;
    idx = 9'(walk_va_q >> (12 + (int'(lvl) - 1) * 9));
    return tbase + {44'd0, idx, 3'b000};
  endfunction

  function automatic bit walk_step(input in_word_t w, output out_word_t res);
    logic [1:0]        lvl;
    logic [RaddrW-1:0] base;
    logic [VaW-1:0]    off_mask;
    res = '0;
    if (w.command == CMD_TRANSLATE) begin
      if (walk_busy_q) return 1'b0;
      walk_va_q = w.virt_addr;
      walk_level_q = LevelRoot;
      walk_busy_q = 1'b1;
      res.kind = KIND_READ;
      res.read_addr = entry_read_addr({root_ppn_q, 12'h000}, LevelRoot);
      res.page_level = LevelRoot;
      return 1'b1;
    end
    if (!walk_busy_q) return 1'b0;
    lvl = walk_level_q;
    base = {w.entry_data[PpnHi:PpnLo], 12'h000};
    res.page_level = lvl;
    if (!w.entry_data[PteValid]) begin
      walk_busy_q = 1'b0;
      walk_level_q = LevelRoot;
      res.kind = KIND_FAULT;
      return 1'b1;
    end
    if (w.entry_data[PteRead] || w.entry_data[PteWrite] || w.entry_data[PteExec] ||
        lvl == LevelLeaf) begin
      off_mask = (39'd1 << (12 + (int'(lvl) - 1) * 9)) - 39'd1;
      walk_busy_q = 1'b0;
      walk_level_q = LevelRoot;
      res.kind = KIND_DONE;
      res.phys_addr = {1'b0, base} + 57'(walk_va_q & off_mask);
      return 1'b1;
    end
    lvl = lvl - 2'd1;
    walk_level_q = lvl;
    res.kind = KIND_READ;
    res.read_addr = entry_read_addr(base, lvl);
    res.page_level = lvl;
    return 1'b1;
  endfunction

  task automatic report_error(input string what);
    err_count++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  task automatic check_result(input out_word_t got);
    out_word_t want;
    if (pending_results.size() == 0) begin
      report_error($sformatf("result word with none expected, kind %0d", got.kind));
      return;
    end
    want = pending_results.pop_front();
    if (got.kind !== want.kind)
      report_error($sformatf("kind %0d, expected %0d", got.kind, want.kind));
    if (got.read_addr !== want.read_addr)
      report_error($sformatf("read_addr %h, expected %h", got.read_addr, want.read_addr));
    if (got.phys_addr !== want.phys_addr)
      report_error($sformatf("phys_addr %h, expected %h", got.phys_addr, want.phys_addr));
    if (got.page_level !== want.page_level)
      report_error($sformatf("page_level %0d, expected %0d", got.page_level, want.page_level));
  endtask

  function automatic void add_row(input cmd_e cmd, input logic [VaW-1:0] va,
                                  input logic [PteW-1:0] pte, input bit typed,
                                  input kind_e kind, input logic [RaddrW-1:0] raddr,
                                  input logic [1:0] lvl);
    probe_t row;
    row.word.command = cmd;
    row.word.virt_addr = va;
    row.word.entry_data = pte;
    row.typed = typed;
    row.want.kind = kind;
    row.want.read_addr = raddr;
    row.want.phys_addr = '0;
    row.want.page_level = lvl;
    directed_rows.push_back(row);
  endfunction

  // Called just after a rising edge; returns at the edge where the word is taken.
  task automatic send_word(input in_word_t w, input bit typed, input out_word_t want,
                           output bit hit);
    int unsigned gap;
    out_word_t   res;
    if ($urandom_range(0, 39) == 0) send_calm = !send_calm;
    gap = send_calm ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i <= w;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    hit = walk_step(w, res);
    if (typed) pending_results.push_back(want);
    else if (hit) pending_results.push_back(res);
  endtask

  task automatic settle_idle();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_root(input logic [RootW-1:0] value);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    root_ppn_q = value;
  endtask

  task automatic random_phase(input int unsigned target);
    int unsigned served;
    int unsigned pick;
    in_word_t    w;
    out_word_t   none;
    bit          hit;
    served = 0;
    none = '0;
    while (served < target) begin
      w.virt_addr = 39'({$urandom, $urandom});
      w.entry_data = {$urandom, $urandom};
      pick = $urandom_range(0, 99);
      if (walk_busy_q) w.command = (pick < 8) ? CMD_TRANSLATE : CMD_ENTRY;
      else w.command = (pick < 8) ? CMD_ENTRY : CMD_TRANSLATE;
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
        w.entry_data[PteValid] = 1'b0;
      end else if (pick < 45) begin
        w.entry_data[PteValid] = 1'b1;
        w.entry_data[PteExec:PteRead] = 3'($urandom_range(1, 7));
      end else begin
        w.entry_data[PteValid] = 1'b1;
        w.entry_data[PteExec:PteRead] = 3'b000;
      end
      send_word(w, 1'b0, none, hit);
      if (hit) served++;
    end
  endtask

  initial begin : result_sink
    int unsigned hold;
    hold = 0;
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        check_result(out_word_o);
        if ($urandom_range(0, 39) == 0) sink_calm = !sink_calm;
        hold = sink_calm ? 0 : $urandom_range(0, 5);
      end
      out_ready_i <= (hold == 0) && !choke;
      if (hold > 0) hold--;
    end
  end

  initial begin : output_choke
    wait (choke_req);
    choke <= 1'b1;
    repeat (ChokeCycles) @(posedge clk_i);
    choke <= 1'b0;
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin : stimulus
    bit hit;
    rst_ni <= 1'b0;
    in_valid_i <= 1'b0;
    in_word_i <= '0;
    cfg_we_i <= 1'b0;
    cfg_wdata_i <= '0;

    // The root page number is still zero from reset for the whole table.
    add_row(CMD_ENTRY, '0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, KIND_READ, '0, LevelRoot);
    add_row(CMD_TRANSLATE, '0, '0, 1'b1, KIND_READ, '0, LevelRoot);
    add_row(CMD_TRANSLATE, 39'h7F_FFFF_FFFF, '0, 1'b0, KIND_READ, '0, LevelRoot);
    add_row(CMD_ENTRY, '0, 64'hFFFF_FFFF_FFFF_FFFE, 1'b1, KIND_FAULT, '0, LevelRoot);
    add_row(CMD_TRANSLATE, 39'h7F_FFFF_FFFF, '0, 1'b1, KIND_READ, 56'hFF8, LevelRoot);
    add_row(CMD_ENTRY, '0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, KIND_READ, '0, LevelRoot);
    add_row(CMD_TRANSLATE, 39'h55_5555_5555, '0, 1'b0, KIND_READ, '0, LevelRoot);
    add_row(CMD_ENTRY, '0, 64'h0015_5555_5555_5401, 1'b0, KIND_READ, '0, LevelRoot);
    add_row(CMD_ENTRY, '0, 64'h003F_FFFF_FFFF_FC01, 1'b0, KIND_READ, '0, LevelRoot);
    add_row(CMD_ENTRY, '0, 64'h0000_0000_0000_0001, 1'b0, KIND_READ, '0, LevelRoot);
    add_row(CMD_TRANSLATE, 39'h2A_AAAA_AAAA, '0, 1'b0, KIND_READ, '0, LevelRoot);
    add_row(CMD_ENTRY, '0, 64'hFFC0_0000_0000_03F1, 1'b0, KIND_READ, '0, LevelRoot);
    add_row(CMD_ENTRY, '0, 64'h0000_0000_1234_5403, 1'b0, KIND_READ, '0, LevelRoot);
    add_row(CMD_TRANSLATE, '0, '0, 1'b0, KIND_READ, '0, LevelRoot);
    add_row(CMD_ENTRY, '0, 64'h0000_0000_0000_0405, 1'b0, KIND_READ, '0, LevelRoot);
    add_row(CMD_TRANSLATE, 39'h7F_FFFF_FFFF, '0, 1'b0, KIND_READ, '0, LevelRoot);
    add_row(CMD_ENTRY, '0, 64'h0000_0000_0000_0001, 1'b0, KIND_READ, '0, LevelRoot);
    add_row(CMD_ENTRY, '0, 64'h0000_0000_0000_0001, 1'b0, KIND_READ, '0, LevelRoot);
    add_row(CMD_ENTRY, '0, '0, 1'b0, KIND_READ, '0, LevelRoot);
    add_row(CMD_TRANSLATE, 39'h12_3456_789A, '0, 1'b0, KIND_READ, '0, LevelRoot);
    add_row(CMD_ENTRY, '0, 64'h0000_0000_0000_2001, 1'b0, KIND_READ, '0, LevelRoot);
    add_row(CMD_ENTRY, '0, 64'hFFFF_FFFF_FFFF_FFF0, 1'b0, KIND_READ, '0, LevelRoot);
    add_row(CMD_ENTRY, '0, '0, 1'b0, KIND_READ, '0, LevelRoot);
    add_row(CMD_TRANSLATE, 39'h00_0000_0FFF, '0, 1'b0, KIND_READ, '0, LevelRoot);
    add_row(CMD_ENTRY, '0, 64'h0000_0000_0000_0C09, 1'b0, KIND_READ, '0, LevelRoot);

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i])
      send_word(directed_rows[i].word, directed_rows[i].typed, directed_rows[i].want, hit);
    settle_idle();

    write_root({RootW{1'b1}});
    choke_req = 1'b1;
    random_phase(200);
    settle_idle();

    write_root(RootW'({$urandom, $urandom}));
    random_phase(200);
    settle_idle();

    write_root('0);
    random_phase(200);
    settle_idle();

    repeat (8) @(posedge clk_i);
    if (err_count == 0 && pending_results.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
